// ----- rtl/rae_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register ALU execute package
// Opcode constants, status and operation codes, and the request and response
// structs between the sequencer and the shared arithmetic unit.
// ----------------------------------------------------------------------------
package rae_pkg;

  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 144;

  localparam logic [15:0] LOAD_IMM_ACTION = 16'h3BC0;
  localparam logic [15:0] ALU_GROUP_BITS  = 16'h0700;
  localparam logic [15:0] LOGIC_SEL_BITS  = 16'h0440;
  localparam logic [15:0] LOGIC_BASE      = 16'h07D6;
  localparam logic [15:0] MATH_BASE       = 16'h0790;
  localparam logic [15:0] CODE_MAX        = 16'd5;

  localparam logic [7:0] FLAG_EQ   = 8'h01;
  localparam logic [7:0] FLAG_GT   = 8'h08;
  localparam logic [7:0] FLAG_LT   = 8'h20;
  localparam logic [7:0] FLAG_CMP  = FLAG_EQ | FLAG_GT | FLAG_LT;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_REG,
    ST_BAD_OP,
    ST_DIV_ZERO
  } status_e;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_AND,
    OP_OR,
    OP_NOT,
    OP_NOR,
    OP_XOR,
    OP_CMP,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_SHL,
    OP_SHR
  } op_e;

  localparam op_e LOGIC_OPS [6] = '{OP_AND, OP_OR, OP_NOT, OP_NOR, OP_XOR, OP_CMP};
  localparam op_e MATH_OPS  [6] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SHL, OP_SHR};

  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic eq;
    logic gt;
  } alu_rsp_t;

  typedef struct packed {
    logic bad_op;
    op_e  op;
  } decode_t;

  function automatic decode_t decode_action(input logic [15:0] action);
    decode_t     dec;
    logic [15:0] code;
    dec.bad_op = 1'b0;
    dec.op     = OP_LOAD;
    code       = '0;
    if (action == LOAD_IMM_ACTION) begin
      dec.op = OP_LOAD;
    end else if ((action & ALU_GROUP_BITS) != ALU_GROUP_BITS) begin
      dec.bad_op = 1'b1;
    end else if ((action & LOGIC_SEL_BITS) == LOGIC_SEL_BITS) begin
      code = action - LOGIC_BASE;
      if (code > CODE_MAX) begin
        dec.bad_op = 1'b1;
      end else begin
        dec.op = LOGIC_OPS[code[2:0]];
      end
    end else begin
      code = action - MATH_BASE;
      if (code > CODE_MAX) begin
        dec.bad_op = 1'b1;
      end else begin
        dec.op = MATH_OPS[code[2:0]];
      end
    end
    return dec;
  endfunction

endpackage

// ----- rtl/rae_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register ALU shared arithmetic unit
// Logic, add, subtract, compare and shifts are computed directly; multiply and
// divide with remainder run radix-2, one bit per cycle, on shared registers.
// ----------------------------------------------------------------------------
module rae_alu
  import rae_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  alu_req_t              req_i,
  input  logic [DATA_WIDTH-1:0] a_i,
  input  logic [DATA_WIDTH-1:0] b_i,
  output alu_rsp_t              rsp_o,
  output logic [DATA_WIDTH-1:0] result_o,
  output logic [DATA_WIDTH-1:0] rem_o
);

  localparam int unsigned SW = $clog2(DATA_WIDTH);
  localparam logic [SW-1:0] LAST_STEP = SW'(DATA_WIDTH - 1);
  localparam logic [DATA_WIDTH-1:0] WIDTH_VAL = DATA_WIDTH'(DATA_WIDTH);

  typedef enum logic {
    A_IDLE,
    A_BUSY
  } alu_state_e;

  alu_state_e            state_q;
  op_e                   op_q;
  logic [DATA_WIDTH-1:0] acc_q;
  logic [DATA_WIDTH-1:0] sh_q;
  logic [DATA_WIDTH-1:0] b_q;
  logic [SW-1:0]         cnt_q;
  logic                  done_q;
  logic                  eq_q;
  logic                  gt_q;

  logic [DATA_WIDTH-1:0] single_res;
  logic                  long_shift;
  logic [DATA_WIDTH-1:0] mul_sum;
  logic [DATA_WIDTH:0]   div_shift;
  logic [DATA_WIDTH:0]   div_diff;
  logic                  div_ok;

  assign long_shift = (b_i >= WIDTH_VAL);

  always_comb begin
    unique case (req_i.op)
      OP_AND:  single_res = a_i & b_i;
      OP_OR:   single_res = a_i | b_i;
      OP_NOT:  single_res = ~b_i;
      OP_NOR:  single_res = ~(a_i | b_i);
      OP_XOR:  single_res = a_i ^ b_i;
      OP_ADD:  single_res = a_i + b_i;
      OP_SUB:  single_res = a_i - b_i;
      OP_SHL:  single_res = long_shift ? '0 : (a_i << b_i[SW-1:0]);
      OP_SHR:  single_res = long_shift ? '0 : (a_i >> b_i[SW-1:0]);
      default: single_res = '0;
    endcase
  end

  // Multiply walks the multiplier from the top bit; divide shifts the
  // dividend out of the same register and the quotient bits in behind it.
  assign mul_sum   = {acc_q[DATA_WIDTH-2:0], 1'b0} + (sh_q[DATA_WIDTH-1] ? b_q : '0);
  assign div_shift = {acc_q, sh_q[DATA_WIDTH-1]};
  assign div_diff  = div_shift - {1'b0, b_q};
  assign div_ok    = ~div_diff[DATA_WIDTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      op_q    <= OP_LOAD;
      acc_q   <= '0;
      sh_q    <= '0;
      b_q     <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      eq_q    <= 1'b0;
      gt_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        A_IDLE: begin
          if (req_i.start) begin
            op_q <= req_i.op;
            if (req_i.op == OP_MUL || req_i.op == OP_DIV) begin
              acc_q   <= '0;
              sh_q    <= a_i;
              b_q     <= b_i;
              cnt_q   <= LAST_STEP;
              state_q <= A_BUSY;
            end else begin
              acc_q  <= single_res;
              eq_q   <= (a_i == b_i);
              gt_q   <= (a_i > b_i);
              done_q <= 1'b1;
            end
          end
        end
        A_BUSY: begin
          if (op_q == OP_MUL) begin
            acc_q <= mul_sum;
            sh_q  <= {sh_q[DATA_WIDTH-2:0], 1'b0};
          end else begin
            acc_q <= div_ok ? div_diff[DATA_WIDTH-1:0] : div_shift[DATA_WIDTH-1:0];
            sh_q  <= {sh_q[DATA_WIDTH-2:0], div_ok};
          end
          if (cnt_q == '0) begin
            done_q  <= 1'b1;
            state_q <= A_IDLE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.eq   = eq_q;
  assign rsp_o.gt   = gt_q;
  assign result_o   = (op_q == OP_DIV) ? sh_q : acc_q;
  assign rem_o      = acc_q;

endmodule

// ----- rtl/register_alu_execute_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register ALU execute unit
// Runs one register-to-register instruction per beat against a register file
// and a flag byte, and returns one result beat for each instruction.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Signals                  | Contents
//  ---------+-----------+--------------------------+------------------------------
//  s_axis   | in        | tvalid, tready, tdata 96 | action, dest_reg, src_reg, imm
//  m_axis   | out       | tvalid, tready, tdata 144| status, dest, remainder, flags
//
//  Each instruction is read, then executed. Load immediate and rejected beats
//  go straight to output; others wait on the shared unit, radix-2 for MUL and
//  DIVMOD; DIVMOD then writes back its remainder and after it its quotient.
//  One instruction is in flight at a time; s_axis_tready_o is high when idle.
//  A result stalled on m_axis holds the next result back, not the next input.
//  Reset clears the register file through per-entry valid bits and the flags.
// ----------------------------------------------------------------------------
module register_alu_execute_unit
  import rae_pkg::*;
#(
  parameter int unsigned NUM_REGS   = 28,
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // action[15:0], dest_reg[23:16], src_reg[31:24], immediate[95:32]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // status[1:0], dest_value[65:2], remainder_value[129:66], flag_bits[137:130]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned AW = $clog2(NUM_REGS);
  localparam logic [8:0] REG_LIMIT = 9'(NUM_REGS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_RUN,
    S_WB_REM,
    S_WB_Q,
    S_OUT
  } state_e;

  state_e                 state_q;
  op_e                    op_q;
  status_e                status_q;
  logic [7:0]             d_q;
  logic [7:0]             s_q;
  logic                   d_ok_q;
  logic [DATA_WIDTH-1:0]  imm_q;
  logic [DATA_WIDTH-1:0]  dest_q;
  logic [DATA_WIDTH-1:0]  rem_q;
  logic [7:0]             flag_q;
  logic [NUM_REGS-1:0]    vld_q;
  logic                   va_q;
  logic                   vb_q;
  logic [DATA_WIDTH-1:0]  rd_a_q;
  logic [DATA_WIDTH-1:0]  rd_b_q;
  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;
  logic [DATA_WIDTH-1:0]  regs_mem [NUM_REGS];

  logic [15:0]           in_action;
  logic [7:0]            in_dest;
  logic [7:0]            in_src;
  logic [DATA_WIDTH-1:0] in_imm;
  logic                  in_beat;
  logic                  in_d_ok;
  logic                  in_s_ok;
  decode_t               in_dec;
  logic [AW-1:0]         ra;
  logic [AW-1:0]         rb;
  logic [8:0]            s_inc;
  logic [AW-1:0]         nxt;
  logic [DATA_WIDTH-1:0] opa;
  logic [DATA_WIDTH-1:0] opb;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  alu_req_t              alu_req;
  alu_rsp_t              alu_rsp;
  logic [DATA_WIDTH-1:0] alu_result;
  logic [DATA_WIDTH-1:0] alu_rem;
  logic [7:0]            cmp_flag;

  assign in_action = s_axis_tdata_i[15:0];
  assign in_dest   = s_axis_tdata_i[23:16];
  assign in_src    = s_axis_tdata_i[31:24];
  assign in_imm    = s_axis_tdata_i[32 +: DATA_WIDTH];
  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_d_ok   = ({1'b0, in_dest} < REG_LIMIT);
  assign in_s_ok   = ({1'b0, in_src} < REG_LIMIT);
  assign in_dec    = decode_action(in_action);

  assign ra    = d_q[AW-1:0];
  assign rb    = s_q[AW-1:0];
  assign s_inc = {1'b0, s_q} + 9'd1;
  assign nxt   = (s_inc >= REG_LIMIT) ? '0 : s_inc[AW-1:0];
  assign opa   = va_q ? rd_a_q : '0;
  assign opb   = vb_q ? rd_b_q : '0;

  assign alu_req.start = (state_q == S_EXEC) && (status_q == ST_OK) && (op_q != OP_LOAD)
                         && !((op_q == OP_DIV) && (opb == '0));
  assign alu_req.op    = op_q;

  assign cmp_flag = alu_rsp.eq ? FLAG_EQ : (alu_rsp.gt ? FLAG_GT : FLAG_LT);

  always_comb begin
    we    = 1'b0;
    waddr = ra;
    wdata = alu_result;
    unique case (state_q)
      S_EXEC: begin
        we    = (status_q == ST_OK) && (op_q == OP_LOAD);
        wdata = imm_q;
      end
      S_RUN:    we = alu_rsp.done && (op_q != OP_CMP) && (op_q != OP_DIV);
      S_WB_REM: begin
        we    = 1'b1;
        waddr = nxt;
        wdata = alu_rem;
      end
      S_WB_Q:   we = 1'b1;
      default:  we = 1'b0;
    endcase
  end

  rae_alu #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (alu_req),
    .a_i     (opa),
    .b_i     (opb),
    .rsp_o   (alu_rsp),
    .result_o(alu_result),
    .rem_o   (alu_rem)
  );

  always_ff @(posedge clk_i) begin
    if (we) begin
      regs_mem[waddr] <= wdata;
    end
    if (state_q == S_READ) begin
      rd_a_q <= regs_mem[ra];
      rd_b_q <= regs_mem[rb];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_LOAD;
      status_q  <= ST_OK;
      d_q       <= '0;
      s_q       <= '0;
      d_ok_q    <= 1'b0;
      imm_q     <= '0;
      dest_q    <= '0;
      rem_q     <= '0;
      flag_q    <= '0;
      vld_q     <= '0;
      va_q      <= 1'b0;
      vb_q      <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (m_valid_q && m_axis_tready_i && (state_q != S_OUT)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            op_q   <= in_dec.op;
            d_q    <= in_dest;
            s_q    <= in_src;
            d_ok_q <= in_d_ok;
            imm_q  <= in_imm;
            rem_q  <= '0;
            if (in_dec.bad_op) begin
              status_q <= ST_BAD_OP;
            end else if (!in_d_ok || ((in_dec.op != OP_LOAD) && !in_s_ok)) begin
              status_q <= ST_BAD_REG;
            end else begin
              status_q <= ST_OK;
            end
            state_q <= S_READ;
          end
        end
        S_READ: begin
          va_q    <= vld_q[ra];
          vb_q    <= vld_q[rb];
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (status_q != ST_OK) begin
            dest_q  <= d_ok_q ? opa : '0;
            state_q <= S_OUT;
          end else if (op_q == OP_LOAD) begin
            dest_q  <= imm_q;
            state_q <= S_OUT;
          end else if ((op_q == OP_DIV) && (opb == '0)) begin
            status_q <= ST_DIV_ZERO;
            dest_q   <= opa;
            state_q  <= S_OUT;
          end else begin
            dest_q  <= opa;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (alu_rsp.done) begin
            if (op_q == OP_CMP) begin
              flag_q  <= (flag_q & ~FLAG_CMP) | cmp_flag;
              state_q <= S_OUT;
            end else if (op_q == OP_DIV) begin
              state_q <= S_WB_REM;
            end else begin
              dest_q  <= alu_result;
              state_q <= S_OUT;
            end
          end
        end
        S_WB_REM: begin
          rem_q   <= alu_rem;
          state_q <= S_WB_Q;
        end
        S_WB_Q: begin
          dest_q  <= alu_result;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {6'd0, flag_q, 64'(rem_q), 64'(dest_q), status_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

// ----- rtl/rae_sva.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register ALU execute port checker
// Watches the stream ports of the execute unit and is bound to its top level.
// ----------------------------------------------------------------------------
module rae_sva
  import rae_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  // A stalled result beat keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // Only one instruction is in flight at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while an instruction is in flight");

  // Only the equal, greater and less flags can ever be set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[137:130] & ~FLAG_CMP) == 8'd0)
    else $error("flag outside the compare flags set");

  // A failed instruction never reports a remainder.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[1:0] != ST_OK) |-> m_axis_tdata_o[129:66] == 64'd0)
    else $error("remainder reported on a failed instruction");

endmodule

bind register_alu_execute_unit rae_sva u_rae_sva (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tdata_i (s_axis_tdata_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register ALU execute unit testbench
// Sends instruction beats into the execute unit and checks every result beat,
// field by field, against a cycle-free model of the register file and flags
// (typed directed rows against their table entry). A short table of directed
// instructions comes first, then random traffic under several patterns of
// source idling and sink back-pressure.
module tb_top;
  import rae_pkg::*;

  localparam int unsigned NUM_REGS       = 28;
  localparam int unsigned DATA_WIDTH     = 64;
  localparam int unsigned RANDOM_ITEMS   = 1400;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 80;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  localparam logic [15:0] ACT_AND = LOGIC_BASE + 16'(OP_AND - OP_AND);
  localparam logic [15:0] ACT_OR  = LOGIC_BASE + 16'(OP_OR - OP_AND);
  localparam logic [15:0] ACT_NOT = LOGIC_BASE + 16'(OP_NOT - OP_AND);
  localparam logic [15:0] ACT_NOR = LOGIC_BASE + 16'(OP_NOR - OP_AND);
  localparam logic [15:0] ACT_XOR = LOGIC_BASE + 16'(OP_XOR - OP_AND);
  localparam logic [15:0] ACT_CMP = LOGIC_BASE + 16'(OP_CMP - OP_AND);
  localparam logic [15:0] ACT_ADD = MATH_BASE + 16'(OP_ADD - OP_ADD);
  localparam logic [15:0] ACT_SUB = MATH_BASE + 16'(OP_SUB - OP_ADD);
  localparam logic [15:0] ACT_MUL = MATH_BASE + 16'(OP_MUL - OP_ADD);
  localparam logic [15:0] ACT_DIV = MATH_BASE + 16'(OP_DIV - OP_ADD);
  localparam logic [15:0] ACT_SHL = MATH_BASE + 16'(OP_SHL - OP_ADD);
  localparam logic [15:0] ACT_SHR = MATH_BASE + 16'(OP_SHR - OP_ADD);

  localparam logic [63:0] ALL_ONES   = '1;
  localparam logic [63:0] END_BITS   = 64'h8000_0000_0000_0001;
  localparam logic [63:0] MIXED_WORD = 64'hDEAD_BEEF_0123_4567;

  typedef struct packed {
    logic [7:0]  flags;
    logic [63:0] remainder;
    logic [63:0] dest;
    status_e     status;
  } exec_result_t;

  typedef struct packed {
    logic [15:0]  action;
    logic [7:0]   dest_reg;
    logic [7:0]   src_reg;
    logic [63:0]  immediate;
    logic         typed;
    exec_result_t result;
  } instr_row_t;

  localparam exec_result_t NO_RESULT = '0;

  localparam instr_row_t DIRECTED_ROWS [27] = '{
    '{ACT_ADD, 8'd0, 8'd1, 64'd0, 1'b1, '{8'h00, 64'd0, 64'd0, ST_OK}},
    '{LOAD_IMM_ACTION, 8'd0, 8'd255, ALL_ONES, 1'b1, '{8'h00, 64'd0, ALL_ONES, ST_OK}},
    '{LOAD_IMM_ACTION, 8'd27, 8'd0, END_BITS, 1'b1, '{8'h00, 64'd0, END_BITS, ST_OK}},
    '{LOAD_IMM_ACTION, 8'd28, 8'd0, ALL_ONES, 1'b1, '{8'h00, 64'd0, 64'd0, ST_BAD_REG}},
    '{16'h0000, 8'd0, 8'd0, 64'd0, 1'b1, '{8'h00, 64'd0, ALL_ONES, ST_BAD_OP}},
    '{16'hFFFF, 8'd0, 8'd0, ALL_ONES, 1'b1, '{8'h00, 64'd0, ALL_ONES, ST_BAD_OP}},
    '{MATH_BASE + CODE_MAX + 16'd1, 8'd0, 8'd0, 64'd0, 1'b1,
      '{8'h00, 64'd0, ALL_ONES, ST_BAD_OP}},
    '{LOGIC_BASE + CODE_MAX + 16'd1, 8'd0, 8'd0, 64'd0, 1'b1,
      '{8'h00, 64'd0, ALL_ONES, ST_BAD_OP}},
    '{ACT_ADD, 8'd0, 8'd28, 64'd0, 1'b1, '{8'h00, 64'd0, ALL_ONES, ST_BAD_REG}},
    '{ACT_ADD, 8'd255, 8'd0, 64'd0, 1'b1, '{8'h00, 64'd0, 64'd0, ST_BAD_REG}},
    '{ACT_DIV, 8'd0, 8'd1, 64'd0, 1'b1, '{8'h00, 64'd0, ALL_ONES, ST_DIV_ZERO}},
    '{ACT_DIV, 8'd0, 8'd27, 64'd0, 1'b0, NO_RESULT},
    '{LOAD_IMM_ACTION, 8'd2, 8'd0, 64'd64, 1'b1, '{8'h00, 64'd0, 64'd64, ST_OK}},
    '{ACT_SHL, 8'd0, 8'd2, 64'd0, 1'b1, '{8'h00, 64'd0, 64'd0, ST_OK}},
    '{LOAD_IMM_ACTION, 8'd6, 8'd0, MIXED_WORD, 1'b0, NO_RESULT},
    '{LOAD_IMM_ACTION, 8'd7, 8'd0, 64'd10, 1'b0, NO_RESULT},
    '{ACT_DIV, 8'd6, 8'd7, 64'd0, 1'b0, NO_RESULT},
    '{ACT_SHR, 8'd27, 8'd7, 64'd0, 1'b0, NO_RESULT},
    '{ACT_CMP, 8'd6, 8'd7, 64'd0, 1'b0, NO_RESULT},
    '{ACT_CMP, 8'd7, 8'd6, 64'd0, 1'b0, NO_RESULT},
    '{ACT_AND, 8'd6, 8'd27, 64'd0, 1'b0, NO_RESULT},
    '{ACT_OR, 8'd6, 8'd7, 64'd0, 1'b0, NO_RESULT},
    '{ACT_NOT, 8'd9, 8'd6, 64'd0, 1'b0, NO_RESULT},
    '{ACT_NOR, 8'd9, 8'd7, 64'd0, 1'b0, NO_RESULT},
    '{ACT_XOR, 8'd9, 8'd6, 64'd0, 1'b0, NO_RESULT},
    '{ACT_SUB, 8'd1, 8'd7, 64'd0, 1'b0, NO_RESULT},
    '{ACT_MUL, 8'd27, 8'd6, 64'd0, 1'b0, NO_RESULT}
  };

  localparam int unsigned PHASE_IDLE  [4] = '{0, 63, 0, 23};
  localparam int unsigned PHASE_STALL [4] = '{0, 0, 63, 23};

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  logic [63:0]  reg_file_model [NUM_REGS];
  logic [7:0]   flag_model;
  exec_result_t pending_results [$];
  int unsigned  err_cnt       = 0;
  int unsigned  quiet_cycles  = 0;
  int unsigned  src_idle_pct  = 0;
  int unsigned  dst_stall_pct = 0;
  logic         hold_req      = 1'b0;
  logic         hold_done     = 1'b0;

  register_alu_execute_unit #(
    .NUM_REGS   (NUM_REGS),
    .DATA_WIDTH (DATA_WIDTH)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever begin
      #2 clk_i = ~clk_i;
    end
  end

  // Executes one instruction on the model state and returns the result beat.
  function automatic exec_result_t run_instruction(input logic [15:0] action,
                                                   input logic [7:0]  dst,
                                                   input logic [7:0]  src,
                                                   input logic [63:0] imm);
    exec_result_t res;
    logic         logic_grp;
    logic [15:0]  code;
    logic [63:0]  a;
    logic [63:0]  b;
    int unsigned  next_idx;
    op_e          op;
    res = '0;
    res.status = ST_OK;
    if (action == LOAD_IMM_ACTION) begin
      if (dst >= NUM_REGS) begin
        res.status = ST_BAD_REG;
      end else begin
        reg_file_model[dst] = imm;
      end
    end else if ((action & ALU_GROUP_BITS) != ALU_GROUP_BITS) begin
      res.status = ST_BAD_OP;
    end else begin
      logic_grp = (action & LOGIC_SEL_BITS) == LOGIC_SEL_BITS;
      code      = action - (logic_grp ? LOGIC_BASE : MATH_BASE);
      if (code > CODE_MAX) begin
        res.status = ST_BAD_OP;
      end else if (dst >= NUM_REGS || src >= NUM_REGS) begin
        res.status = ST_BAD_REG;
      end else begin
        op = logic_grp ? op_e'(OP_AND + code[2:0]) : op_e'(OP_ADD + code[2:0]);
        a  = reg_file_model[dst];
        b  = reg_file_model[src];
        case (op)
          OP_AND: a = a & b;
          OP_OR:  a = a | b;
          OP_NOT: a = ~b;
          OP_NOR: a = ~(a | b);
          OP_XOR: a = a ^ b;
          OP_ADD: a = a + b;
          OP_SUB: a = a - b;
          OP_MUL: a = a * b;
          OP_SHL: a = (b >= DATA_WIDTH) ? '0 : a << b[5:0];
          OP_SHR: a = (b >= DATA_WIDTH) ? '0 : a >> b[5:0];
          default: ;
        endcase
        if (op == OP_CMP) begin
          flag_model = flag_model & ~FLAG_CMP;
          if (a == b) begin
            flag_model = flag_model | FLAG_EQ;
          end else if (a > b) begin
            flag_model = flag_model | FLAG_GT;
          end else begin
            flag_model = flag_model | FLAG_LT;
          end
        end else if (op == OP_DIV && b == '0) begin
          res.status = ST_DIV_ZERO;
        end else begin
          if (op == OP_DIV) begin
            next_idx = (int'(src) + 1 >= NUM_REGS) ? 0 : int'(src) + 1;
            res.remainder = a % b;
            reg_file_model[next_idx] = res.remainder;
            a = a / b;
          end
          reg_file_model[dst] = a;
        end
      end
    end
    res.dest  = (dst < NUM_REGS) ? reg_file_model[dst] : '0;
    res.flags = flag_model;
    return res;
  endfunction

  function automatic logic [15:0] action_for(input op_e op);
    case (op)
      OP_AND:  return ACT_AND;
      OP_OR:   return ACT_OR;
      OP_NOT:  return ACT_NOT;
      OP_NOR:  return ACT_NOR;
      OP_XOR:  return ACT_XOR;
      OP_CMP:  return ACT_CMP;
      OP_ADD:  return ACT_ADD;
      OP_SUB:  return ACT_SUB;
      OP_MUL:  return ACT_MUL;
      OP_DIV:  return ACT_DIV;
      OP_SHL:  return ACT_SHL;
      OP_SHR:  return ACT_SHR;
      default: return LOAD_IMM_ACTION;
    endcase
  endfunction

  function automatic logic [63:0] random_word();
    case ($urandom_range(0, 5))
      0:       return {$urandom, $urandom};
      1:       return 64'($urandom_range(0, 70));
      2:       return ALL_ONES;
      3:       return 64'd1 << $urandom_range(0, 63);
      4:       return 64'd0;
      default: return 64'($urandom);
    endcase
  endfunction

  // Mostly well-formed instructions on valid registers, with some bad
  // indices, raw action words and actions just outside the valid codes.
  function automatic instr_row_t random_instr();
    instr_row_t  row;
    int unsigned pick;
    row           = '0;
    pick          = $urandom_range(0, 99);
    row.immediate = random_word();
    row.dest_reg  = 8'($urandom_range(0, NUM_REGS - 1));
    row.src_reg   = 8'($urandom_range(0, NUM_REGS - 1));
    if (pick < 30) begin
      row.action = LOAD_IMM_ACTION;
      if (pick < 3) begin
        row.dest_reg = 8'($urandom_range(0, 255));
      end
    end else if (pick < 85) begin
      row.action = action_for(op_e'($urandom_range(OP_AND, OP_SHR)));
      if (pick >= 79) begin
        row.dest_reg = 8'($urandom_range(0, 255));
        row.src_reg  = 8'($urandom_range(0, 255));
      end
    end else if (pick < 93) begin
      row.action   = 16'($urandom_range(0, 65535));
      row.dest_reg = 8'($urandom_range(0, 255));
      row.src_reg  = 8'($urandom_range(0, 255));
    end else if (pick < 97) begin
      row.action = ($urandom_range(0, 1) ? LOGIC_BASE : MATH_BASE) + CODE_MAX
                   + 16'($urandom_range(1, 4));
    end else begin
      row.action = ($urandom_range(0, 1) ? LOGIC_BASE : MATH_BASE) - 16'd1;
    end
    return row;
  endfunction

  // Offers one instruction beat and records its expected result on acceptance.
  task automatic send_instr(input instr_row_t row);
    exec_result_t res;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {row.immediate, row.src_reg, row.dest_reg, row.action};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready_o);
    res = run_instruction(row.action, row.dest_reg, row.src_reg, row.immediate);
    pending_results.push_back(row.typed ? row.result : res);
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end
      m_axis_tready_i <= ($urandom_range(0, 99) >= dst_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    exec_result_t got;
    exec_result_t want;
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = exec_result_t'(m_axis_tdata_o[137:0]);
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t: result beat with nothing expected, got %h", $time, m_axis_tdata_o);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("dest_value", want.dest, got.dest);
        check_field("remainder_value", want.remainder, got.remainder);
        check_field("flag_bits", 64'(want.flags), 64'(got.flags));
      end
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    instr_row_t row;
    for (int i = 0; i < NUM_REGS; i++) begin
      reg_file_model[i] = '0;
    end
    flag_model = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      send_instr(DIRECTED_ROWS[i]);
    end

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  = PHASE_IDLE[ph];
      dst_stall_pct = PHASE_STALL[ph];
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        if (ph == 0 && n == 100) begin
          hold_req = 1'b1;
        end
        row = random_instr();
        send_instr(row);
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rae_pkg.sv
rtl/rae_alu.sv
rtl/register_alu_execute_unit.sv
rtl/rae_sva.sv
dv/tb_top.sv
